>>> design/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, codes and constants of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;

  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned HEIGHT_W  = 13;
  localparam int unsigned OROW_W    = 12;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned PIX_W     = 24;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned NUM_W     = 13;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned RECIP_W   = 18;
  localparam int unsigned RECIP_SH  = 18;
  localparam int unsigned PROD_W    = NUM_W + RECIP_W;

  localparam int unsigned CMD_QDEPTH = 4;
  localparam int unsigned OUT_QDEPTH = 8;
  localparam int unsigned PIPE_DEPTH = 3;
  localparam int unsigned OQ_CNT_W   = $clog2(OUT_QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

  typedef struct packed {
    logic               wr;
    logic               emit;
    logic [WIDTH_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
    logic               top_ok;
    logic               bot_ok;
    logic               left_ok;
    logic               right_ok;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } res_t;

  // Reciprocal of twice the neighbor count, scaled by 2^RECIP_SH and rounded up.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      4'd9:    r = 18'd14564;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/box_blur_3x3_rgb_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// 3x3 box blur on an RGB raster stream with edge-aware rounded averaging.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: a request is taken when in_push
// is high and in_full is low. Pixel requests carry one pixel in raster order;
// drain requests flush one pending result each once the frame is complete.
// Results leave through out_empty/out_pop; the oldest result is on the out_
// ports while out_empty is low. Frame size comes from the cfg_ write port and
// is latched at the first pixel of each frame.
// One request is taken per cycle while in_full is low. A request becomes at
// most one line-buffer command, but the first drain of a one-row frame becomes
// two, and in_full stays high until the second is queued. A result reaches the
// out_ ports through the command queue, line-buffer read, window update, then
// sum and divide into the output queue. Results refer to the pixel one row
// and one pixel behind.
// A stalled receiver fills the eight-entry output queue and then the
// four-entry command queue, after which in_full rises.
// Reset empties both queues and returns the frame position to the start; the
// frame size registers return to 640 by 480. No clearing pass is needed.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_opcode,
  input  logic [bb3_pkg::CH_W-1:0]      in_pixel_blue,
  input  logic [bb3_pkg::CH_W-1:0]      in_pixel_green,
  input  logic [bb3_pkg::CH_W-1:0]      in_pixel_red,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bb3_pkg::CH_W-1:0]      out_blue,
  output logic [bb3_pkg::CH_W-1:0]      out_green,
  output logic [bb3_pkg::CH_W-1:0]      out_red,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_wdata
);

  logic                         enq_valid;
  bb3_pkg::cmd_t                enq_cmd;
  logic                         cq_full;
  logic                         cq_empty;
  bb3_pkg::cmd_t                cq_cmd;
  logic                         cq_pop;
  logic [bb3_pkg::OQ_CNT_W-1:0] oq_count;
  logic                         res_push;
  bb3_pkg::res_t                res;
  bb3_pkg::res_t                oq_res;

  bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_pixel_blue  (in_pixel_blue),
    .in_pixel_green (in_pixel_green),
    .in_pixel_red   (in_pixel_red),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .enq_valid      (enq_valid),
    .enq_cmd        (enq_cmd),
    .q_full         (cq_full)
  );

  bb3_queue #(
    .WIDTH ($bits(bb3_pkg::cmd_t)),
    .DEPTH (bb3_pkg::CMD_QDEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (enq_valid),
    .wr_data (enq_cmd),
    .rd_en   (cq_pop),
    .rd_data (cq_cmd),
    .full    (cq_full),
    .empty   (cq_empty),
    .count   ()
  );

  bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cq_empty),
    .cmd       (cq_cmd),
    .cmd_pop   (cq_pop),
    .out_count (oq_count),
    .res_push  (res_push),
    .res       (res)
  );

  bb3_queue #(
    .WIDTH ($bits(bb3_pkg::res_t)),
    .DEPTH (bb3_pkg::OUT_QDEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (oq_res),
    .full    (),
    .empty   (out_empty),
    .count   (oq_count)
  );

  assign out_red   = oq_res.red;
  assign out_green = oq_res.green;
  assign out_blue  = oq_res.blue;
  assign out_last  = oq_res.last;

endmodule

>>> design/bb3_queue.sv
// ----------------------------------------------------------------------------
// bb3_queue
// Small synchronous FIFO used between the front and back and on the output.
// ----------------------------------------------------------------------------
module bb3_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> design/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// Accepts requests, tracks frame position and turns each request into
// line-buffer commands for the back end.
// ----------------------------------------------------------------------------
module bb3_front #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_opcode,
  input  logic [bb3_pkg::CH_W-1:0]         in_pixel_blue,
  input  logic [bb3_pkg::CH_W-1:0]         in_pixel_green,
  input  logic [bb3_pkg::CH_W-1:0]         in_pixel_red,
  input  logic                             cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                             enq_valid,
  output bb3_pkg::cmd_t                    enq_cmd,
  input  logic                             q_full
);

  logic [bb3_pkg::WIDTH_W-1:0]  cfg_w_r;
  logic [bb3_pkg::HEIGHT_W-1:0] cfg_h_r;
  logic [bb3_pkg::WIDTH_W-1:0]  fw_r, fw_nxt;
  logic [bb3_pkg::HEIGHT_W-1:0] fh_r, fh_nxt;
  logic [bb3_pkg::HEIGHT_W-1:0] in_row_r, in_row_nxt;
  logic [bb3_pkg::WIDTH_W-1:0]  in_col_r, in_col_nxt;
  logic [bb3_pkg::OROW_W-1:0]   out_row_r, out_row_nxt;
  logic [bb3_pkg::WIDTH_W-1:0]  out_col_r, out_col_nxt;
  logic                         pend_r, pend_nxt;
  bb3_pkg::cmd_t                pend_cmd_r, pend_cmd_nxt;

  logic                         accept;
  logic                         start;
  logic [bb3_pkg::WIDTH_W-1:0]  w_clamp;
  logic [bb3_pkg::HEIGHT_W-1:0] h_clamp;
  logic [bb3_pkg::WIDTH_W-1:0]  w_use;
  logic [bb3_pkg::HEIGHT_W-1:0] h_use;
  logic [bb3_pkg::WIDTH_W-1:0]  col_b;
  logic [bb3_pkg::WIDTH_W-1:0]  col_c;
  logic                         row_end;
  logic                         col_end;
  logic                         emit;
  logic [bb3_pkg::PIX_W-1:0]    pixel;
  bb3_pkg::cmd_t                res_cmd;

  assign in_full = q_full || pend_r;
  assign accept  = in_push && !in_full;
  assign start   = (in_row_r == '0) && (in_col_r == '0) &&
                   (out_row_r == '0) && (out_col_r == '0);
  assign pixel   = {in_pixel_red, in_pixel_green, in_pixel_blue};

  always_comb begin
    if (cfg_w_r == '0) begin
      w_clamp = 11'd1;
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_clamp = 11'(MAX_WIDTH);
    end else begin
      w_clamp = cfg_w_r;
    end
    if (cfg_h_r == '0) begin
      h_clamp = 13'd1;
    end else if (32'(cfg_h_r) > bb3_pkg::MAX_HEIGHT) begin
      h_clamp = 13'(bb3_pkg::MAX_HEIGHT);
    end else begin
      h_clamp = cfg_h_r;
    end
  end

  assign w_use   = (in_opcode == bb3_pkg::OP_PIXEL && start) ? w_clamp : fw_r;
  assign h_use   = (in_opcode == bb3_pkg::OP_PIXEL && start) ? h_clamp : fh_r;
  assign col_b   = (in_col_r + 1'b1 == w_use) ? '0 : in_col_r + 1'b1;
  assign col_c   = (col_b + 1'b1 == w_use) ? '0 : col_b + 1'b1;
  assign row_end = (13'(out_row_r) == h_use - 1'b1);
  assign col_end = (out_col_r == w_use - 1'b1);
  assign emit    = (in_row_r >= 13'd2) || ((in_row_r == 13'd1) && (in_col_r != '0));

  always_comb begin
    res_cmd.wr       = 1'b0;
    res_cmd.emit     = 1'b1;
    res_cmd.col      = in_col_r;
    res_cmd.pixel    = pixel;
    res_cmd.top_ok   = (out_row_r != '0);
    res_cmd.bot_ok   = !row_end;
    res_cmd.left_ok  = (out_col_r != '0);
    res_cmd.right_ok = !col_end;
    res_cmd.last     = row_end && col_end;
  end

  always_comb begin
    fw_nxt       = fw_r;
    fh_nxt       = fh_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    pend_nxt     = pend_r;
    pend_cmd_nxt = pend_cmd_r;
    enq_valid    = 1'b0;
    enq_cmd      = res_cmd;
    if (pend_r) begin
      enq_cmd = pend_cmd_r;
      if (!q_full) begin
        enq_valid = 1'b1;
        pend_nxt  = 1'b0;
      end
    end else if (accept) begin
      if (in_opcode == bb3_pkg::OP_PIXEL) begin
        if (start) begin
          fw_nxt = w_clamp;
          fh_nxt = h_clamp;
        end
        if (in_row_r < h_use) begin
          enq_valid    = 1'b1;
          enq_cmd.wr   = 1'b1;
          enq_cmd.emit = emit;
          in_col_nxt   = col_b;
          if (col_b == '0) begin
            in_row_nxt = in_row_r + 1'b1;
          end
        end
      end else if (in_row_r >= fh_r) begin
        enq_valid = 1'b1;
        if (fh_r == 13'd1 && out_row_r == '0 && out_col_r == '0) begin
          enq_cmd.emit     = 1'b0;
          enq_cmd.top_ok   = 1'b0;
          enq_cmd.bot_ok   = 1'b0;
          enq_cmd.left_ok  = 1'b0;
          enq_cmd.right_ok = 1'b0;
          enq_cmd.last     = 1'b0;
          pend_nxt         = 1'b1;
          pend_cmd_nxt     = res_cmd;
          pend_cmd_nxt.col = col_b;
          in_col_nxt       = col_c;
        end else begin
          in_col_nxt = col_b;
        end
      end
      if (enq_valid && (emit || in_opcode == bb3_pkg::OP_DRAIN)) begin
        if (col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
        if (row_end && col_end) begin
          in_row_nxt  = '0;
          in_col_nxt  = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_cmd_r <= pend_cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= bb3_pkg::RESET_WIDTH;
      cfg_h_r   <= bb3_pkg::RESET_HEIGHT;
      fw_r      <= bb3_pkg::RESET_WIDTH;
      fh_r      <= bb3_pkg::RESET_HEIGHT;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == bb3_pkg::CFG_FRAME_WIDTH) begin
        cfg_w_r <= cfg_wdata[bb3_pkg::WIDTH_W-1:0];
      end
      if (cfg_we && cfg_index == bb3_pkg::CFG_FRAME_HEIGHT) begin
        cfg_h_r <= cfg_wdata;
      end
      fw_r      <= fw_nxt;
      fh_r      <= fh_nxt;
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      pend_r    <= pend_nxt;
    end
  end

endmodule

>>> design/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// Line buffers, 3x3 window, masked sums and rounded division by the
// neighbor count, as a three-stage pipeline.
// ----------------------------------------------------------------------------
module bb3_back #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_empty,
  input  bb3_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic [bb3_pkg::OQ_CNT_W-1:0]  out_count,
  output logic                          res_push,
  output bb3_pkg::res_t                 res
);

  localparam int unsigned LB_DEPTH = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
  localparam int unsigned AW       = (LB_DEPTH > 1) ? $clog2(LB_DEPTH) : 1;

  logic [bb3_pkg::PIX_W-1:0] lb0_mem [LB_DEPTH];
  logic [bb3_pkg::PIX_W-1:0] lb1_mem [LB_DEPTH];

  logic                      a_vld_r;
  bb3_pkg::cmd_t             a_cmd_r;
  logic [bb3_pkg::PIX_W-1:0] a_top_r;
  logic [bb3_pkg::PIX_W-1:0] a_mid_r;
  logic [AW-1:0]             rd_col;
  logic [AW-1:0]             a_col;
  logic                      fwd;

  logic [2:0][2:0][bb3_pkg::PIX_W-1:0] win_r;
  logic                      b_vld_r;
  logic [2:0]                b_row_ok_r;
  logic [2:0]                b_col_ok_r;
  logic                      b_last_r;

  logic [bb3_pkg::SUM_W-1:0] sum_r_b, sum_g_b, sum_b_b;
  logic [bb3_pkg::CNT_W-1:0] cnt_b;
  logic                      c_vld_r;
  logic [bb3_pkg::SUM_W-1:0] c_sum_r_r, c_sum_g_r, c_sum_b_r;
  logic [bb3_pkg::CNT_W-1:0] c_cnt_r;
  logic                      c_last_r;

  logic [bb3_pkg::RECIP_W-1:0] rcp;
  logic [bb3_pkg::PROD_W-1:0]  prod_r, prod_g, prod_b;

  assign cmd_pop = !cmd_empty &&
                   (out_count < bb3_pkg::OQ_CNT_W'(bb3_pkg::OUT_QDEPTH - bb3_pkg::PIPE_DEPTH));
  assign rd_col  = cmd.col[AW-1:0];
  assign a_col   = a_cmd_r.col[AW-1:0];
  assign fwd     = a_vld_r && a_cmd_r.wr && (a_col == rd_col);

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_cmd_r <= cmd;
      a_mid_r <= fwd ? a_cmd_r.pixel : lb0_mem[rd_col];
      a_top_r <= fwd ? a_mid_r : lb1_mem[rd_col];
    end
    if (a_vld_r && a_cmd_r.wr) begin
      lb0_mem[a_col] <= a_cmd_r.pixel;
      lb1_mem[a_col] <= a_mid_r;
    end
    if (a_vld_r) begin
      win_r      <= {{a_cmd_r.pixel, a_mid_r, a_top_r}, win_r[2], win_r[1]};
      b_row_ok_r <= {a_cmd_r.bot_ok, 1'b1, a_cmd_r.top_ok};
      b_col_ok_r <= {a_cmd_r.right_ok, 1'b1, a_cmd_r.left_ok};
      b_last_r   <= a_cmd_r.last;
    end
    c_sum_r_r <= sum_r_b;
    c_sum_g_r <= sum_g_b;
    c_sum_b_r <= sum_b_b;
    c_cnt_r   <= cnt_b;
    c_last_r  <= b_last_r;
  end

  always_comb begin
    sum_r_b = '0;
    sum_g_b = '0;
    sum_b_b = '0;
    cnt_b   = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (b_col_ok_r[c] && b_row_ok_r[r]) begin
          sum_r_b = sum_r_b + 12'(win_r[c][r][23:16]);
          sum_g_b = sum_g_b + 12'(win_r[c][r][15:8]);
          sum_b_b = sum_b_b + 12'(win_r[c][r][7:0]);
          cnt_b   = cnt_b + 4'd1;
        end
      end
    end
  end

  assign rcp    = bb3_pkg::recip(c_cnt_r);
  assign prod_r = ({c_sum_r_r, 1'b0} + 13'(c_cnt_r)) * 31'(rcp);
  assign prod_g = ({c_sum_g_r, 1'b0} + 13'(c_cnt_r)) * 31'(rcp);
  assign prod_b = ({c_sum_b_r, 1'b0} + 13'(c_cnt_r)) * 31'(rcp);

  assign res_push  = c_vld_r;
  assign res.red   = prod_r[bb3_pkg::RECIP_SH +: bb3_pkg::CH_W];
  assign res.green = prod_g[bb3_pkg::RECIP_SH +: bb3_pkg::CH_W];
  assign res.blue  = prod_b[bb3_pkg::RECIP_SH +: bb3_pkg::CH_W];
  assign res.last  = c_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= cmd_pop;
      b_vld_r <= a_vld_r && a_cmd_r.emit;
      c_vld_r <= b_vld_r;
    end
  end

endmodule

>>> design/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur, bound to the top level.
// ----------------------------------------------------------------------------
module bb3_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_full,
  input logic                     out_empty,
  input logic                     out_pop,
  input logic [bb3_pkg::CH_W-1:0] out_blue,
  input logic [bb3_pkg::CH_W-1:0] out_green,
  input logic [bb3_pkg::CH_W-1:0] out_red,
  input logic                     out_last
);

  // Reset leaves both sides empty and ready.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result holds until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty &&
      $stable({out_red, out_green, out_blue, out_last}))
    else $error("waiting result changed");

  // The pipeline cannot produce a result directly after reset.
  a_latency: assert property (@(posedge clk)
    $fell(out_empty) |-> $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
    else $error("result appeared too early after reset");

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (.*);

>>> tb/sv/box_blur_3x3_rgb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_checker
// Watches the request, result and write ports of the box blur, predicts each
// blurred pixel from its own line history and compares it field by field.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_checker
  import bb3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic                 in_opcode,
  input  logic [CH_W-1:0]      in_pixel_blue,
  input  logic [CH_W-1:0]      in_pixel_green,
  input  logic [CH_W-1:0]      in_pixel_red,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic [CH_W-1:0]      out_blue,
  input  logic [CH_W-1:0]      out_green,
  input  logic [CH_W-1:0]      out_red,
  input  logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   blur_pending
);

  localparam int HIST_DEPTH = 2 * DEF_MAX_WIDTH + 3;

  logic [PIX_W-1:0]    pixel_hist [HIST_DEPTH];
  res_t                blur_q [$];
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int unsigned         frame_w, frame_h, row_pos, col_pos, next_out;

  function automatic logic [CH_W-1:0] round_mean(int unsigned sum, int unsigned n);
    return CH_W'((2 * sum + n) / (2 * n));
  endfunction

  function automatic res_t blur_at(int unsigned p);
    int unsigned      r, c, sb, sg, sr, n;
    int               rr, cc;
    logic [PIX_W-1:0] px;
    res_t             res;
    r = p / frame_w;
    c = p % frame_w;
    sb = 0;
    sg = 0;
    sr = 0;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = int'(r) + dr;
        cc = int'(c) + dc;
        if (rr >= 0 && rr < int'(frame_h) && cc >= 0 && cc < int'(frame_w)) begin
          px = pixel_hist[(rr * frame_w + cc) % HIST_DEPTH];
          sb += px[7:0];
          sg += px[15:8];
          sr += px[23:16];
          n++;
        end
      end
    end
    res.blue = round_mean(sb, n);
    res.green = round_mean(sg, n);
    res.red = round_mean(sr, n);
    res.last = (p + 1 == frame_w * frame_h);
    return res;
  endfunction

  task automatic predict_blur();
    blur_q.push_back(blur_at(next_out));
    next_out++;
    if (next_out >= frame_w * frame_h) begin
      row_pos = 0;
      col_pos = 0;
      next_out = 0;
    end
  endtask

  task automatic take_request();
    int unsigned q;
    if (in_opcode == OP_PIXEL) begin
      if (row_pos == 0 && col_pos == 0 && next_out == 0) begin
        frame_w = (width_reg < 1) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH
                                                                   : width_reg;
        frame_h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT
                                                                   : height_reg;
      end
      if (row_pos >= frame_h) return;
      q = row_pos * frame_w + col_pos;
      pixel_hist[q % HIST_DEPTH] = {in_pixel_red, in_pixel_green, in_pixel_blue};
      col_pos++;
      if (col_pos >= frame_w) begin
        col_pos = 0;
        row_pos++;
      end
      if (q >= frame_w + 1) predict_blur();
    end else if (row_pos >= frame_h) begin
      predict_blur();
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      blur_q.delete();
      fail_count = 0;
      width_reg <= RESET_WIDTH;
      height_reg <= RESET_HEIGHT;
      frame_w = RESET_WIDTH;
      frame_h = RESET_HEIGHT;
      row_pos = 0;
      col_pos = 0;
      next_out = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_WIDTH) width_reg <= cfg_wdata[WIDTH_W-1:0];
        else height_reg <= cfg_wdata[HEIGHT_W-1:0];
      end
      if (out_pop && !out_empty) begin
        if (blur_q.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d last=%0d", $time,
                   out_red, out_green, out_blue, out_last);
          fail_count++;
        end else begin
          want = blur_q.pop_front();
          if (want.red !== out_red || want.green !== out_green ||
              want.blue !== out_blue || want.last !== out_last) begin
            $display("%0t: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                     $time, want.red, want.green, want.blue, want.last,
                     out_red, out_green, out_blue, out_last);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) take_request();
    end
    blur_pending = blur_q.size();
  end

endmodule

>>> tb/sv/tb_box_blur_3x3_rgb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_top
// Drives whole frames of pixel and drain requests at several frame sizes,
// with stray requests mixed in, and gives the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb_top;
  import bb3_pkg::*;

  logic                 clk, rst_n;
  logic                 in_push, in_full, in_opcode;
  logic [CH_W-1:0]      in_pixel_blue, in_pixel_green, in_pixel_red;
  logic                 out_empty, out_pop, out_last;
  logic [CH_W-1:0]      out_blue, out_green, out_red;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count, blur_pending, random_sent;
  bit                   calm, long_hold, held;
  longint               cycles;

  box_blur_3x3_rgb_top u_dut (.*);
  box_blur_3x3_rgb_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("box_blur_3x3_rgb_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    out_pop = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (long_hold && !held) begin
        out_pop <= 0;
        repeat (400) @(posedge clk);
        held = 1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_pop <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_pop <= 1;
      end
    end
  end

  task automatic send(logic op, logic [CH_W-1:0] b, logic [CH_W-1:0] g,
                      logic [CH_W-1:0] r);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_push <= 1;
    in_opcode <= op;
    in_pixel_blue <= b;
    in_pixel_green <= g;
    in_pixel_red <= r;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned wv, int unsigned hv);
    in_push <= 0;
    @(posedge clk);
    while (blur_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= CFG_W'(wv);
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= CFG_W'(hv);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [CH_W-1:0] chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return CH_W'($urandom);
    endcase
  endfunction

  // One full frame, with noise when noisy is set: stray drains mid-frame, a
  // dropped pixel once the frame is complete, and a drain after the flush.
  task automatic run_frame(int unsigned wv, int unsigned hv, bit noisy);
    int unsigned w, h, n, drains;
    w = (wv & 2047) < 1 ? 1 : (wv & 2047) > 1024 ? 1024 : (wv & 2047);
    h = (hv & 8191) < 1 ? 1 : (hv & 8191) > 4096 ? 4096 : (hv & 8191);
    n = w * h;
    drains = (n < w + 1) ? n : w + 1;
    set_geometry(wv, hv);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send(OP_DRAIN, chan(), chan(), chan());
      send(OP_PIXEL, chan(), chan(), chan());
    end
    if (noisy && $urandom_range(0, 2) == 0) send(OP_PIXEL, chan(), chan(), chan());
    for (int unsigned i = 0; i < drains; i++) send(OP_DRAIN, chan(), chan(), chan());
    if (noisy && $urandom_range(0, 2) == 0) send(OP_DRAIN, chan(), chan(), chan());
    if (noisy) random_sent += n + drains;
  endtask

  initial begin
    rst_n = 0;
    in_push = 0;
    in_opcode = OP_PIXEL;
    in_pixel_blue = 0;
    in_pixel_green = 0;
    in_pixel_red = 0;
    cfg_we = 0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_wdata = 0;
    calm = 0;
    long_hold = 0;
    random_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_geometry(3, 2);
    send(OP_DRAIN, 8'd255, 8'd255, 8'd255);
    for (int i = 0; i < 6; i++) begin
      send(OP_PIXEL, i[0] ? 8'd255 : 8'd0, i[1] ? 8'd255 : 8'd0, i[0] ? 8'd0 : 8'd255);
      if (i == 2) send(OP_DRAIN, 8'd0, 8'd0, 8'd0);
    end
    send(OP_PIXEL, 8'd7, 8'd7, 8'd7);
    for (int i = 0; i < 4; i++) send(OP_DRAIN, 8'd0, 8'd0, 8'd0);
    send(OP_DRAIN, 8'd0, 8'd0, 8'd0);

    run_frame(0, 0, 0);
    run_frame(1, 1, 0);
    run_frame(24, 3, 0);
    run_frame(1, 9, 0);
    run_frame(2, 5, 0);
    run_frame(3, 1, 0);

    random_sent = 0;
    while (random_sent < 1500) begin
      if (random_sent > 400) long_hold = 1;
      if ($urandom_range(0, 5) == 0)
        run_frame($urandom_range(0, 12), $urandom_range(0, 8), 1);
      else
        run_frame($urandom_range(1, 8), $urandom_range(1, 6), 1);
    end
    calm = 1;
    run_frame(5, 4, 1);
    run_frame(1, 3, 1);

    in_push <= 0;
    @(posedge clk);
    while (blur_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("box_blur_3x3_rgb_top regression: pass");
    end else begin
      $display("box_blur_3x3_rgb_top regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
design/bb3_pkg.sv
design/bb3_queue.sv
design/bb3_front.sv
design/bb3_back.sv
design/box_blur_3x3_rgb_top.sv
design/bb3_checker.sv
tb/sv/box_blur_3x3_rgb_checker.sv
tb/sv/tb_box_blur_3x3_rgb_top.sv
